// ----- hw/rtl/knn_inverse_distance_interpolator_macros.svh -----
// assertion helpers for the interpolator
`ifndef KNN_INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH
`define KNN_INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH

// same-cycle implication under clk_i / rst_ni
`define KNN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under clk_i / rst_ni
`define KNN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/knn_idw_pkg.sv -----
package knn_idw_pkg;

  // default sizes
  localparam int unsigned MaxPointsDef    = 8192;
  localparam int unsigned MaxNeighborsDef = 16;

  // field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned TargetW  = 13;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned NbrW     = 5;
  localparam int unsigned GradW    = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned EntryW   = 3 * CoordW + ValueW;

  // internal arithmetic widths
  localparam int unsigned SqW     = 34;  // exact squared distance
  localparam int unsigned DistW   = 25;  // floor(sqrt(sq << 16))
  localparam int unsigned WeightW = 31;  // floor(2^40 / (d + eps))
  localparam int unsigned GradQW  = 33;  // unsaturated gradient

  // constants
  localparam logic [ValueW-1:0] ValueOne = 16'd32768;
  localparam logic [ValueW-1:0] EpsQ16   = 16'd655;
  localparam logic [GradW-1:0]  GradMax  = 24'hFFFFFF;

  // register reset values
  localparam logic [NbrW-1:0]   InterpNbrRst = 5'd10;
  localparam logic [NbrW-1:0]   CheckNbrRst  = 5'd4;
  localparam logic [GradW-1:0]  GradLimitRst = 24'd6554;
  localparam logic [ValueW-1:0] FallbackRst  = 16'd28180;

  // request kinds
  localparam logic [KindW-1:0] KindAdd    = 2'd0;
  localparam logic [KindW-1:0] KindInterp = 2'd1;
  localparam logic [KindW-1:0] KindCheck  = 2'd2;
  localparam logic [KindW-1:0] KindNone   = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusRange = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegInterpNbr = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCheckNbr  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGradLimit = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFallback  = 2'd3;

endpackage

// ----- hw/rtl/knn_idw_if.sv -----
// request channel
interface knn_idw_in_if import knn_idw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic [ValueW-1:0]        point_value;
  logic [TargetW-1:0]       target;
  logic                     write_back;

  modport source (output valid, kind, pos_x, pos_y, pos_z, point_value, target, write_back,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, point_value, target, write_back,
                output ready);
endinterface

// result channel
interface knn_idw_out_if import knn_idw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  result_value;
  logic               smooth;
  logic [GradW-1:0]   worst_gradient;

  modport source (output valid, status, result_value, smooth, worst_gradient, input ready);
  modport sink (input valid, status, result_value, smooth, worst_gradient, output ready);
endinterface

// ----- hw/rtl/knn_idw_ram.sv -----
module knn_idw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- hw/rtl/knn_inverse_distance_interpolator.sv -----
// add, unused kind and out-of-range target: from idle to the finish state, which loads the output register
// query: store scan over the N stored points (one read per cycle),
//   then per neighbor a bit-serial sqrt and a D-step divider (D = 53
//   at defaults), plus for interpolation one more D-step divide for the interpolated mean
// one word in flight at a time; a new word is taken while the last result waits
// reset clears the point count, the control state and loads the register defaults
module knn_inverse_distance_interpolator import knn_idw_pkg::*; #(
  parameter int unsigned MAX_POINTS    = MaxPointsDef,
  parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  knn_idw_in_if.sink          in_i,
  knn_idw_out_if.source       out_o
);

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned LW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned TW   = (CW > TargetW) ? CW : TargetW;
  localparam int unsigned TOTW = WeightW + KW;
  localparam int unsigned PRW  = WeightW + ValueW;
  localparam int unsigned SUMW = PRW + KW;
  localparam int unsigned NUMW = SUMW + 1;
  localparam int unsigned DENW = TOTW + 1;
  localparam int unsigned DCW  = $clog2(NUMW);
  localparam int unsigned SCW  = $clog2(DistW);

  typedef enum logic [3:0] {
    S_IDLE, S_TGT_RD, S_TGT_CAP, S_SCAN, S_NB_RD, S_SQRT, S_DIST, S_DIV,
    S_MUL, S_ACC, S_CHK, S_NEXT, S_MEAN, S_FINAL, S_FINISH
  } state_e;

  typedef enum logic [1:0] {RET_WEIGHT, RET_GRAD, RET_MEAN} ret_e;

  state_e state_q;
  ret_e   ret_q;

  // registers
  logic [NbrW-1:0]   interp_nbr_q, check_nbr_q;
  logic [GradW-1:0]  grad_limit_q;
  logic [ValueW-1:0] fallback_q;

  logic [CW-1:0]            count_q;
  logic                     is_check_q, wb_q;
  logic [AW-1:0]            t_q;
  logic signed [CoordW-1:0] tx_q, ty_q, tz_q;
  logic [ValueW-1:0]        tv_q, nv_q;
  logic [KW-1:0]            k_q, best_n_q, pj_q;

  // scan pipeline
  logic [CW-1:0]  scan_q;
  logic           p1_v_q, p2_v_q, p3_v_q;
  logic [AW-1:0]  p1_idx_q, p2_idx_q, p3_idx_q;
  logic [31:0]    dx2_q, dy2_q, dz2_q;
  logic [SqW-1:0] p3_sq_q;

  logic [SqW-1:0] best_sq_q  [MAX_NEIGHBORS];
  logic [AW-1:0]  best_idx_q [MAX_NEIGHBORS];

  // sqrt and divider
  logic [2*DistW-1:0] sq_rad_q;
  logic [DistW-1:0]   root_q;
  logic [DistW+1:0]   sq_rem_q;
  logic [SCW-1:0]     sq_cnt_q;
  logic [NUMW-1:0]    num_q;
  logic [DENW-1:0]    den_q, div_rem_q;
  logic [DCW-1:0]     div_cnt_q;

  logic [PRW-1:0]   prod_q;
  logic [SUMW-1:0]  sum_q;
  logic [TOTW-1:0]  tot_q;
  logic             ok_q;
  logic [GradW-1:0] worst_q;

  logic [StatusW-1:0] res_status_q;
  logic [ValueW-1:0]  res_value_q;
  logic               res_smooth_q;
  logic [GradW-1:0]   res_worst_q;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [ValueW-1:0]  out_value_q;
  logic               out_smooth_q;
  logic [GradW-1:0]   out_worst_q;

  // memory port
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [EntryW-1:0] wr_data, rd_data;

  knn_idw_ram #(.Width(EntryW), .Depth(MAX_POINTS)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  logic accept;
  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.result_value   = out_value_q;
  assign out_o.smooth         = out_smooth_q;
  assign out_o.worst_gradient = out_worst_q;

  // request decode
  logic [TW-1:0]     t_ext, count_ext;
  logic [ValueW-1:0] in_val_sat, fallback_sat;
  logic              full;
  assign t_ext        = TW'(in_i.target);
  assign count_ext    = TW'(count_q);
  assign in_val_sat   = (in_i.point_value > ValueOne) ? ValueOne : in_i.point_value;
  assign fallback_sat = (fallback_q > ValueOne) ? ValueOne : fallback_q;
  assign full         = (count_q == CW'(MAX_POINTS));

  // memory address and write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = {in_i.pos_x, in_i.pos_y, in_i.pos_z, in_val_sat};
    if (accept && in_i.kind == KindAdd && !full) begin
      wr_en = 1'b1;
    end else if (state_q == S_FINAL && wb_q) begin
      wr_en   = 1'b1;
      wr_addr = t_q;
      wr_data = {tx_q, ty_q, tz_q, res_value_q};
    end
  end

  always_comb begin
    case (state_q)
      S_SCAN:  rd_addr = scan_q[AW-1:0];
      S_NB_RD: rd_addr = best_idx_q[pj_q[LW-1:0]];
      default: rd_addr = t_q;
    endcase
  end

  // squared coordinate differences of the point just read
  logic signed [CoordW:0]     dx, dy, dz;
  logic signed [2*CoordW+1:0] mx, my, mz;
  always_comb begin
    dx = $signed({rd_data[63], rd_data[63:48]}) - $signed({tx_q[CoordW-1], tx_q});
    dy = $signed({rd_data[47], rd_data[47:32]}) - $signed({ty_q[CoordW-1], ty_q});
    dz = $signed({rd_data[31], rd_data[31:16]}) - $signed({tz_q[CoordW-1], tz_q});
    mx = dx * dx;
    my = dy * dy;
    mz = dz * dz;
  end

  // sorted insertion into the neighbor list
  logic [MAX_NEIGHBORS-1:0] le;
  logic                     any_gt, ins;
  always_comb begin
    any_gt = 1'b0;
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      le[j] = (j < int'(best_n_q)) && (best_sq_q[j] <= p3_sq_q);
      if ((j < int'(best_n_q)) && (best_sq_q[j] > p3_sq_q)) begin
        any_gt = 1'b1;
      end
    end
    ins = p3_v_q && (p3_idx_q != t_q) && ((best_n_q < k_q) || any_gt);
  end

  // one sqrt digit
  logic [DistW+1:0] sq_sh, sq_trial, sq_rem_d;
  logic [DistW-1:0] root_d;
  always_comb begin
    sq_sh    = {sq_rem_q[DistW-1:0], sq_rad_q[2*DistW-1 -: 2]};
    sq_trial = {root_q, 2'b01};
    if (sq_sh >= sq_trial) begin
      sq_rem_d = sq_sh - sq_trial;
      root_d   = {root_q[DistW-2:0], 1'b1};
    end else begin
      sq_rem_d = sq_sh;
      root_d   = {root_q[DistW-2:0], 1'b0};
    end
  end

  // one restoring divide step
  logic [DENW:0]   div_sh;
  logic            div_ge;
  logic [DENW-1:0] div_rem_d;
  always_comb begin
    div_sh    = {div_rem_q, num_q[NUMW-1]};
    div_ge    = (div_sh >= {1'b0, den_q});
    div_rem_d = div_ge ? DENW'(div_sh - {1'b0, den_q}) : div_sh[DENW-1:0];
  end

  // gradient evaluation
  logic [ValueW-1:0] dv;
  logic [GradQW-1:0] grad;
  logic [GradW-1:0]  grad_sat;
  logic [ValueW-1:0] mean_sat;
  always_comb begin
    dv       = (tv_q >= nv_q) ? (tv_q - nv_q) : (nv_q - tv_q);
    grad     = num_q[GradQW-1:0];
    grad_sat = (grad > GradQW'(GradMax)) ? GradMax : grad[GradW-1:0];
    mean_sat = (num_q > NUMW'(ValueOne)) ? ValueOne : num_q[ValueW-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= RET_WEIGHT;
      count_q      <= '0;
      interp_nbr_q <= InterpNbrRst;
      check_nbr_q  <= CheckNbrRst;
      grad_limit_q <= GradLimitRst;
      fallback_q   <= FallbackRst;
      best_n_q     <= '0;
      k_q          <= '0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      p3_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegInterpNbr: interp_nbr_q <= cfg_data_i[NbrW-1:0];
          RegCheckNbr:  check_nbr_q  <= cfg_data_i[NbrW-1:0];
          RegGradLimit: grad_limit_q <= cfg_data_i[GradW-1:0];
          RegFallback:  fallback_q   <= cfg_data_i[ValueW-1:0];
          default: ;
        endcase
      end

      // output drained, unless a new word is loaded this cycle
      if (out_valid_q && out_o.ready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_value_q  <= '0;
            res_smooth_q <= 1'b0;
            res_worst_q  <= '0;
            is_check_q   <= (in_i.kind == KindCheck);
            wb_q         <= in_i.write_back;
            t_q          <= t_ext[AW-1:0];
            if (in_i.kind == KindAdd) begin
              state_q <= S_FINISH;
              if (full) begin
                res_status_q <= StatusFull;
              end else begin
                res_status_q <= StatusOk;
                count_q      <= count_q + CW'(1);
              end
            end else if (in_i.kind == KindNone) begin
              res_status_q <= StatusOk;
              state_q      <= S_FINISH;
            end else if (t_ext >= count_ext) begin
              res_status_q <= StatusRange;
              state_q      <= S_FINISH;
            end else begin
              res_status_q <= StatusOk;
              if (in_i.kind == KindCheck) begin
                k_q <= (int'(check_nbr_q) > MAX_NEIGHBORS) ?
                       KW'(MAX_NEIGHBORS) : KW'(check_nbr_q);
              end else begin
                k_q <= (int'(interp_nbr_q) > MAX_NEIGHBORS) ?
                       KW'(MAX_NEIGHBORS) : KW'(interp_nbr_q);
              end
              state_q <= S_TGT_RD;
            end
          end
        end

        S_TGT_RD: state_q <= S_TGT_CAP;

        S_TGT_CAP: begin
          tx_q     <= rd_data[63:48];
          ty_q     <= rd_data[47:32];
          tz_q     <= rd_data[31:16];
          tv_q     <= rd_data[15:0];
          scan_q   <= '0;
          best_n_q <= '0;
          pj_q     <= '0;
          ok_q     <= 1'b1;
          worst_q  <= '0;
          sum_q    <= '0;
          tot_q    <= '0;
          state_q  <= S_SCAN;
        end

        S_SCAN: begin
          // issue one read a cycle
          p1_v_q   <= (scan_q != count_q);
          p1_idx_q <= scan_q[AW-1:0];
          if (scan_q != count_q) begin
            scan_q <= scan_q + CW'(1);
          end
          // squares, then their sum
          p2_v_q   <= p1_v_q;
          p2_idx_q <= p1_idx_q;
          dx2_q    <= mx[31:0];
          dy2_q    <= my[31:0];
          dz2_q    <= mz[31:0];
          p3_v_q   <= p2_v_q;
          p3_idx_q <= p2_idx_q;
          p3_sq_q  <= SqW'(dx2_q) + SqW'(dy2_q) + SqW'(dz2_q);
          // insert into the list
          if (ins) begin
            for (int j = 0; j < MAX_NEIGHBORS; j++) begin
              if (!le[j]) begin
                if (j == 0 || le[(j == 0) ? 0 : j - 1]) begin
                  best_sq_q[j]  <= p3_sq_q;
                  best_idx_q[j] <= p3_idx_q;
                end else begin
                  best_sq_q[j]  <= best_sq_q[(j == 0) ? 0 : j - 1];
                  best_idx_q[j] <= best_idx_q[(j == 0) ? 0 : j - 1];
                end
              end
            end
            if (best_n_q < k_q) begin
              best_n_q <= best_n_q + KW'(1);
            end
          end
          if (scan_q == count_q && !p1_v_q && !p2_v_q && !p3_v_q) begin
            if (best_n_q != '0) begin
              state_q <= S_NB_RD;
            end else if (is_check_q) begin
              res_smooth_q <= 1'b1;
              state_q      <= S_FINISH;
            end else begin
              res_value_q <= fallback_sat;
              state_q     <= S_FINAL;
            end
          end
        end

        S_NB_RD: begin
          sq_rad_q <= {best_sq_q[pj_q[LW-1:0]], 16'b0};
          root_q   <= '0;
          sq_rem_q <= '0;
          sq_cnt_q <= '0;
          state_q  <= S_SQRT;
        end

        S_SQRT: begin
          if (sq_cnt_q == '0) begin
            nv_q <= rd_data[15:0];
          end
          sq_rad_q <= {sq_rad_q[2*DistW-3:0], 2'b00};
          root_q   <= root_d;
          sq_rem_q <= sq_rem_d;
          sq_cnt_q <= sq_cnt_q + SCW'(1);
          if (sq_cnt_q == SCW'(DistW - 1)) begin
            state_q <= S_DIST;
          end
        end

        S_DIST: begin
          div_rem_q <= '0;
          div_cnt_q <= '0;
          if (!is_check_q) begin
            num_q   <= NUMW'(64'd1 << 40);
            den_q   <= DENW'(root_q) + DENW'(EpsQ16);
            ret_q   <= RET_WEIGHT;
            state_q <= S_DIV;
          end else if (root_q == '0) begin
            num_q   <= '0;
            state_q <= S_CHK;
          end else begin
            num_q   <= NUMW'({dv, 17'b0});
            den_q   <= DENW'(root_q);
            ret_q   <= RET_GRAD;
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          div_rem_q <= div_rem_d;
          num_q     <= {num_q[NUMW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(NUMW - 1)) begin
            case (ret_q)
              RET_WEIGHT: state_q <= S_MUL;
              RET_GRAD:   state_q <= S_CHK;
              RET_MEAN:   state_q <= S_MEAN;
              default:    state_q <= S_MEAN;
            endcase
          end
        end

        S_MUL: begin
          prod_q  <= num_q[WeightW-1:0] * nv_q;
          tot_q   <= tot_q + TOTW'(num_q[WeightW-1:0]);
          state_q <= S_ACC;
        end

        S_ACC: begin
          sum_q   <= sum_q + SUMW'(prod_q);
          state_q <= S_NEXT;
        end

        S_CHK: begin
          if (grad > GradQW'(grad_limit_q)) begin
            res_smooth_q <= 1'b0;
            res_worst_q  <= grad_sat;
            state_q      <= S_FINISH;
          end else begin
            if (grad_sat > worst_q) begin
              worst_q <= grad_sat;
            end
            state_q <= S_NEXT;
          end
        end

        S_NEXT: begin
          if (pj_q + KW'(1) != best_n_q) begin
            pj_q    <= pj_q + KW'(1);
            state_q <= S_NB_RD;
          end else if (is_check_q) begin
            res_smooth_q <= ok_q;
            res_worst_q  <= worst_q;
            state_q      <= S_FINISH;
          end else begin
            // rounded mean: (2 sum + tot) / (2 tot)
            num_q     <= {sum_q, 1'b0} + NUMW'(tot_q);
            den_q     <= {tot_q, 1'b0};
            div_rem_q <= '0;
            div_cnt_q <= '0;
            ret_q     <= RET_MEAN;
            state_q   <= S_DIV;
          end
        end

        S_MEAN: begin
          res_value_q <= mean_sat;
          state_q     <= S_FINAL;
        end

        S_FINAL: state_q <= S_FINISH;

        S_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_value_q  <= res_value_q;
            out_smooth_q <= res_smooth_q;
            out_worst_q  <= res_worst_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `include "knn_inverse_distance_interpolator_macros.svh"

  `KNN_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_POINTS), "point count past capacity")
  `KNN_ASSERT_NOW(a_list_bound, state_q == S_SCAN, best_n_q <= k_q, "neighbor list overfilled")
  `KNN_ASSERT_NOW(a_write_slot, wr_en, state_q == S_IDLE || state_q == S_FINAL, "stray store write")
  `KNN_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "word accepted without work")

endmodule

// ----- test/testbench.sv -----
module testbench import knn_idw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = MaxPointsDef;
  localparam int unsigned NbrMax     = MaxNeighborsDef;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [ValueW-1:0]        point_value;
    logic [TargetW-1:0]       target;
    logic                     write_back;
  } request_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  result_value;
    logic               smooth;
    logic [GradW-1:0]   worst_gradient;
  } answer_t;

  // models the point store and the neighbor arithmetic, queues predicted answers
  class idw_scoreboard;
    logic signed [CoordW-1:0] px[StoreDepth];
    logic signed [CoordW-1:0] py[StoreDepth];
    logic signed [CoordW-1:0] pz[StoreDepth];
    logic [ValueW-1:0]        pv[StoreDepth];
    int unsigned              point_count;
    int unsigned              near_idx[NbrMax];
    longint unsigned          near_sq[NbrMax];
    int unsigned              near_n;
    logic [NbrW-1:0]          interp_k;
    logic [NbrW-1:0]          check_k;
    logic [GradW-1:0]         grad_limit;
    logic [ValueW-1:0]        fallback;
    answer_t                  pending_answers[$];
    int unsigned              mismatches;

    function void reset_state();
      point_count = 0;
      interp_k    = InterpNbrRst;
      check_k     = CheckNbrRst;
      grad_limit  = GradLimitRst;
      fallback    = FallbackRst;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegInterpNbr) interp_k = data[NbrW-1:0];
      else if (idx == RegCheckNbr) check_k = data[NbrW-1:0];
      else if (idx == RegGradLimit) grad_limit = data[GradW-1:0];
      else if (idx == RegFallback) fallback = data[ValueW-1:0];
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned sq_dist(int unsigned a, int unsigned b);
      longint dx;
      longint dy;
      longint dz;
      dx = longint'(px[a]) - longint'(px[b]);
      dy = longint'(py[a]) - longint'(py[b]);
      dz = longint'(pz[a]) - longint'(pz[b]);
      return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // insertion sort into the k-best list, ties keep the lower index
    function void find_nearest(int unsigned t, int unsigned k);
      int unsigned kk;
      int unsigned j;
      longint unsigned s;
      kk = (k > NbrMax) ? NbrMax : k;
      near_n = 0;
      if (kk == 0) return;
      for (int unsigned i = 0; i < point_count; i++) begin
        if (i == t) continue;
        s = sq_dist(i, t);
        if (near_n == kk && s >= near_sq[kk-1]) continue;
        if (near_n < kk) begin
          j = near_n;
          near_n++;
        end else begin
          j = kk - 1;
        end
        while (j > 0 && near_sq[j-1] > s) begin
          near_sq[j]  = near_sq[j-1];
          near_idx[j] = near_idx[j-1];
          j--;
        end
        near_sq[j]  = s;
        near_idx[j] = i;
      end
    endfunction

    function void note_request(request_t r);
      answer_t         a;
      longint unsigned d;
      longint unsigned w;
      longint unsigned sum;
      longint unsigned tot;
      longint unsigned res;
      longint unsigned dv;
      longint unsigned g;
      longint unsigned gs;
      longint unsigned worst;
      int unsigned     t;
      a = '{StatusOk, '0, 1'b0, '0};
      t = 32'(r.target);
      if (r.kind == KindAdd) begin
        if (point_count >= StoreDepth) begin
          a.status = StatusFull;
        end else begin
          px[point_count] = r.pos_x;
          py[point_count] = r.pos_y;
          pz[point_count] = r.pos_z;
          pv[point_count] = (r.point_value > ValueOne) ? ValueOne : r.point_value;
          point_count++;
        end
      end else if (r.kind == KindNone) begin
        // nothing happens
      end else if (t >= point_count) begin
        a.status = StatusRange;
      end else if (r.kind == KindInterp) begin
        find_nearest(t, 32'(interp_k));
        if (near_n == 0) begin
          res = 64'((fallback > ValueOne) ? ValueOne : fallback);
        end else begin
          sum = 0;
          tot = 0;
          for (int unsigned i = 0; i < near_n; i++) begin
            d = isqrt(near_sq[i] << 16);
            w = (64'd1 << 40) / (d + EpsQ16);
            sum += w * pv[near_idx[i]];
            tot += w;
          end
          res = (2 * sum + tot) / (2 * tot);
          if (res > ValueOne) res = ValueOne;
        end
        if (r.write_back) pv[t] = res[ValueW-1:0];
        a.result_value = res[ValueW-1:0];
      end else begin
        worst = 0;
        a.smooth = 1'b1;
        find_nearest(t, 32'(check_k));
        for (int unsigned i = 0; i < near_n; i++) begin
          dv = 64'((pv[t] > pv[near_idx[i]]) ? pv[t] - pv[near_idx[i]] :
                                                 pv[near_idx[i]] - pv[t]);
          d  = isqrt(near_sq[i] << 16);
          g  = (d == 0) ? 0 : (dv << 17) / d;
          gs = (g > 64'(GradMax)) ? 64'(GradMax) : g;
          if (g > grad_limit) begin
            a.smooth = 1'b0;
            worst = gs;
            break;
          end
          if (gs > worst) worst = gs;
        end
        a.worst_gradient = worst[GradW-1:0];
      end
      pending_answers = {pending_answers, a};
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      if (pending_answers.size() == 0) begin
        flag("result word with no request outstanding");
        return;
      end
      e = pending_answers.pop_front();
      if (got.status !== e.status)
        flag($sformatf("status exp %0d got %0d", e.status, got.status));
      if (got.result_value !== e.result_value)
        flag($sformatf("result_value exp %0d got %0d", e.result_value, got.result_value));
      if (got.smooth !== e.smooth)
        flag($sformatf("smooth exp %0d got %0d", e.smooth, got.smooth));
      if (got.worst_gradient !== e.worst_gradient)
        flag($sformatf("worst_gradient exp %0d got %0d", e.worst_gradient,
                       got.worst_gradient));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  knn_idw_in_if        in_if ();
  knn_idw_out_if       out_if ();

  idw_scoreboard  sb;
  bit             no_gaps;
  int unsigned    stall_left;
  longint unsigned cycles;

  knn_inverse_distance_interpolator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("knn_inverse_distance_interpolator regression: fail");
      $finish;
    end
  end

  // result side: sample at rising edge, draw a stall after each word
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_answer('{out_if.status, out_if.result_value, out_if.smooth,
                        out_if.worst_gradient});
      stall_left = no_gaps ? 0 : $urandom_range(0, 9);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // one request word, optional idle gap first
  task automatic send(request_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= r.kind;
    in_if.pos_x       <= r.pos_x;
    in_if.pos_y       <= r.pos_y;
    in_if.pos_z       <= r.pos_z;
    in_if.point_value <= r.point_value;
    in_if.target      <= r.target;
    in_if.write_back  <= r.write_back;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // all four registers, block idle
  task automatic write_regs(logic [CfgDataW-1:0] ik, logic [CfgDataW-1:0] ck,
                            logic [CfgDataW-1:0] lim, logic [CfgDataW-1:0] fb);
    logic [CfgDataW-1:0] vals[4];
    vals = '{ik, ck, lim, fb};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(CfgIdxW'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic request_t mk(logic [KindW-1:0] k, int x, int y, int z,
                                  int unsigned v, int unsigned t, bit wb);
    request_t r;
    r = '{k, CoordW'(x), CoordW'(y), CoordW'(z), ValueW'(v), TargetW'(t), wb};
    return r;
  endfunction

  // mostly clustered points and in-range targets, some wide values and misses
  function automatic request_t random_request();
    request_t    r;
    int unsigned p;
    r.pos_x       = CoordW'($urandom());
    r.pos_y       = CoordW'($urandom());
    r.pos_z       = CoordW'($urandom());
    r.point_value = ($urandom_range(0, 4) == 0) ? ValueW'($urandom()) :
                    ValueW'($urandom_range(0, 32768));
    r.target      = TargetW'($urandom());
    r.write_back  = 1'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      r.pos_x = CoordW'(int'($urandom_range(0, 1023)) - 512);
      r.pos_y = CoordW'(int'($urandom_range(0, 1023)) - 512);
      r.pos_z = CoordW'(int'($urandom_range(0, 1023)) - 512);
    end
    if (sb.point_count > 0 && $urandom_range(0, 9) != 0)
      r.target = TargetW'($urandom_range(0, sb.point_count - 1));
    p = $urandom_range(0, 99);
    if (p < 40 || sb.point_count < 3) r.kind = KindAdd;
    else if (p < 70) r.kind = KindInterp;
    else if (p < 95) r.kind = KindCheck;
    else r.kind = KindNone;
    return r;
  endfunction

  initial begin
    sb = new();
    sb.reset_state();
    no_gaps          = 1'b0;
    stall_left       = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegInterpNbr;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.kind       = KindNone;
    in_if.pos_x      = '0;
    in_if.pos_y      = '0;
    in_if.pos_z      = '0;
    in_if.point_value = '0;
    in_if.target     = '0;
    in_if.write_back = 1'b0;
    out_if.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty store, lone point, extreme coordinates, coincident points
    send(mk(KindInterp, 0, 0, 0, 0, 0, 1'b0));
    send(mk(KindNone, -1, -1, -1, 65535, 8191, 1'b1));
    send(mk(KindAdd, -32768, -32768, -32768, 0, 0, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 0, 1'b0));
    send(mk(KindCheck, 0, 0, 0, 0, 0, 1'b0));
    send(mk(KindAdd, 32767, 32767, 32767, 65535, 0, 1'b0));
    send(mk(KindAdd, -32768, -32768, -32768, 32768, 0, 1'b0));
    send(mk(KindAdd, 0, 0, 0, 12345, 0, 1'b0));
    send(mk(KindAdd, 0, 0, 256, 100, 0, 1'b0));
    send(mk(KindAdd, 0, 0, -256, 30000, 0, 1'b0));
    send(mk(KindCheck, 0, 0, 0, 0, 0, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 0, 1'b1));
    send(mk(KindCheck, 0, 0, 0, 0, 2, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 3, 1'b0));
    send(mk(KindCheck, 0, 0, 0, 0, 3, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 1, 1'b1));
    send(mk(KindInterp, 0, 0, 0, 0, 8191, 1'b0));
    send(mk(KindCheck, 0, 0, 0, 0, 6, 1'b0));
    drain();

    // random phases under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_regs(1, 1, 0, 0);
        1: write_regs(16, 16, 24'hFFFFFF, 32768);
        2: write_regs(0, 0, 1, 16'hFFFF);
        3: write_regs(24'hFFFFFF, 24'hFFFFF1, CfgDataW'($urandom_range(0, 200000)),
                      CfgDataW'($urandom()));
        default: write_regs(10, 4, 6554, 28180);
      endcase
      no_gaps = (ph == 2);
      for (int n = 0; n < 18; n++) send(random_request());
      drain();
    end

    // out-of-range targets and a final query
    no_gaps = 1'b0;
    send(mk(KindAdd, 5, 5, 5, 5, 0, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 8191, 1'b1));
    send(mk(KindCheck, 0, 0, 0, 0, 8191, 1'b0));
    send(mk(KindInterp, 0, 0, 0, 0, 0, 1'b0));
    drain();

    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("knn_inverse_distance_interpolator regression: pass");
    end else begin
      $display("knn_inverse_distance_interpolator regression: fail");
    end
    $finish;
  end

endmodule
